// ===== hdl/mpq_pkg.sv =====
// shared constants, command and status codes, and store control types
// for the min priority queue; no dependencies
`timescale 1ns / 1ps

package mpq_pkg;

    // field widths
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 2;

    // default queue depth and index width sized for the largest supported depth
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int IDX_W           = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // sequencer to store: one read port, one write port, scan compare enable
    typedef struct packed {
        logic                    rd_en;
        logic                    scan;
        logic [IDX_W-1:0]        rd_addr;
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_data;
    } t_ram_ctrl;

    // store to sequencer: registered read data and running minimum
    typedef struct packed {
        logic signed [DATA_W-1:0] rd_data;
        logic [IDX_W-1:0]         rd_addr;
        logic signed [DATA_W-1:0] best_val;
        logic [IDX_W-1:0]         best_idx;
    } t_ram_stat;

endpackage

// ===== hdl/min_priority_queue_unit.sv =====
// Min priority queue held as an unordered array. Insert, clear, remove on an
// empty queue and the unused command code never raise busy, and o_done pulses
// in the cycle after start. A remove with n stored entries whose minimum sits
// at index b below n - 1 keeps busy high while it scans the n entries (S_SCAN),
// lets the last compare land (S_WAIT), picks the minimum (S_PICK), moves the
// n - 1 - b later entries down (S_SHIFT) and finishes (S_LAST); when the minimum
// is the last stored entry nothing moves. o_done pulses as busy falls; the single
// read port of the entry memory serves one entry a cycle. o_done stands for
// exactly one cycle and the receiver cannot hold it off; o_removed_value and
// o_status hold until the next start.
// depends on mpq_pkg and mpq_store
`timescale 1ns / 1ps

module min_priority_queue_unit #(
    parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [mpq_pkg::CMD_W-1:0]         i_command,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_value,
    output logic                              busy,
    output logic                              o_done,
    output logic signed [mpq_pkg::DATA_W-1:0] o_removed_value,
    output logic [mpq_pkg::ST_W-1:0]          o_status,
    output logic                              o_is_empty,
    output logic                              o_is_full
);
    import mpq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_LAST  = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_n, n_n;
    logic [AW-1:0]            r_idx, n_idx;
    logic                     r_shift_wr, n_shift_wr;
    logic                     r_done, n_done;
    logic signed [DATA_W-1:0] r_removed, n_removed;
    logic [ST_W-1:0]          r_status, n_status;

    t_ram_ctrl ram_ctrl;
    t_ram_stat ram_stat;

    mpq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ram_ctrl),
        .o_stat  (ram_stat)
    );

    // sequencer and store control
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_idx      = r_idx;
        n_shift_wr = 1'b0;
        n_done     = 1'b0;
        n_removed  = r_removed;
        n_status   = r_status;
        ram_ctrl   = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_done    = 1'b1;
                    case (i_command)
                        CMD_INSERT: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_ctrl.wr_en   = 1'b1;
                                ram_ctrl.wr_addr = IDX_W'(r_count);
                                ram_ctrl.wr_data = i_value;
                                n_count          = r_count + CW'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                                n_idx   = '0;
                                n_n     = r_count;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // one entry read per cycle into the minimum compare
            S_SCAN: begin
                ram_ctrl.rd_en   = 1'b1;
                ram_ctrl.scan    = 1'b1;
                ram_ctrl.rd_addr = IDX_W'(r_idx);
                if (CW'(r_idx) == r_n - CW'(1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            // last compare lands
            S_WAIT: begin
                n_state = S_PICK;
            end
            // minimum known, start closing the gap unless it was the tail
            S_PICK: begin
                if (CW'(ram_stat.best_idx[AW-1:0]) + CW'(1) == r_n) begin
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_removed = ram_stat.best_val;
                    n_status  = ST_OK;
                    n_count   = r_n - CW'(1);
                end else begin
                    n_idx   = ram_stat.best_idx[AW-1:0] + AW'(1);
                    n_state = S_SHIFT;
                end
            end
            // read the next later entry, written one place down in the following cycle
            S_SHIFT: begin
                ram_ctrl.rd_en   = 1'b1;
                ram_ctrl.rd_addr = IDX_W'(r_idx);
                n_shift_wr       = 1'b1;
                if (CW'(r_idx) == r_n - CW'(1)) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_LAST: begin
                n_state   = S_IDLE;
                n_done    = 1'b1;
                n_removed = ram_stat.best_val;
                n_status  = ST_OK;
                n_count   = r_n - CW'(1);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // move-down write of the entry read in the previous cycle
        if (r_shift_wr) begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = ram_stat.rd_addr - IDX_W'(1);
            ram_ctrl.wr_data = ram_stat.rd_data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_shift_wr <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_shift_wr <= n_shift_wr;
            r_done     <= n_done;
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    // result transfer
    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_is_empty      = (r_count == '0);
    assign o_is_full       = (r_count == CW'(QUEUE_DEPTH));

endmodule

// ===== hdl/mpq_store.sv =====
// entry memory with registered read port and the shared signed minimum compare
// depends on mpq_pkg
`timescale 1ns / 1ps

module mpq_store #(
    parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpq_pkg::t_ram_ctrl i_ctrl,
    output mpq_pkg::t_ram_stat o_stat
);
    import mpq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic signed [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic [IDX_W-1:0]         r_rd_addr;
    logic                     r_cmp_vld;
    logic signed [DATA_W-1:0] r_best_val;
    logic [IDX_W-1:0]         r_best_idx;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr[AW-1:0]] <= i_ctrl.wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_ctrl.rd_addr[AW-1:0]];
            r_rd_addr <= i_ctrl.rd_addr;
        end
    end

    // compare enable is the scan read enable, registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_ctrl.rd_en & i_ctrl.scan;
        end
    end

    // running minimum, entry zero seeds it, strict less keeps lowest index on ties
    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && ((r_rd_addr == '0) || (r_rd_data < r_best_val))) begin
            r_best_val <= r_rd_data;
            r_best_idx <= r_rd_addr;
        end
    end

    assign o_stat.rd_data  = r_rd_data;
    assign o_stat.rd_addr  = r_rd_addr;
    assign o_stat.best_val = r_best_val;
    assign o_stat.best_idx = r_best_idx;

endmodule

// ===== hdl/mpq_checker.sv =====
// port-level checks for the min priority queue, bound to the top level
// depends on mpq_pkg and min_priority_queue_unit
`timescale 1ns / 1ps

module mpq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_done,
    input logic signed [mpq_pkg::DATA_W-1:0] o_removed_value,
    input logic [mpq_pkg::ST_W-1:0]          o_status,
    input logic                              o_is_empty,
    input logic                              o_is_full
);
    import mpq_pkg::*;

    // an accepted command shows a result or keeps working in the next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted command left no trace");

    // a long command ends with its result transfer
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result");

    // remove on empty leaves the queue empty and returns zero
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_EMPTY)) |-> (o_is_empty && (o_removed_value == '0)))
        else $error("empty status with inconsistent result");

    // dropped insert only when full
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_is_full && !o_is_empty))
        else $error("full status while queue not full");

endmodule

bind min_priority_queue_unit mpq_checker u_mpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_removed_value (o_removed_value),
    .o_status        (o_status),
    .o_is_empty      (o_is_empty),
    .o_is_full       (o_is_full)
);

// ===== verif/min_priority_queue_unit_tb.sv =====
// self-checking testbench for min_priority_queue_unit: directed and random
// insert/remove/clear traffic checked against a shadow queue kept in the bench
// depends on mpq_pkg and the min_priority_queue_unit rtl
`timescale 1ns / 1ps

module min_priority_queue_unit_tb;

    import mpq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int ITEM_TARGET = 1400;
    localparam int TAIL_ITEMS  = 150;
    localparam int DRAIN_WAIT  = 4 * QUEUE_DEPTH + 16;
    localparam int STALL_LIMIT = 2000;

    // unused command code, a no-op in the block
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } t_queue_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [ST_W-1:0]          status;
        logic                     is_empty;
        logic                     is_full;
    } t_queue_outcome;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [CMD_W-1:0]         i_command = CMD_NOP;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     busy;
    logic                     o_done;
    logic signed [DATA_W-1:0] o_removed_value;
    logic [ST_W-1:0]          o_status;
    logic                     o_is_empty;
    logic                     o_is_full;

    t_queue_cmd     cmd_q[$];
    t_queue_outcome outcome_q[$];

    // shadow copy of the queue contents
    logic signed [DATA_W-1:0] shadow_entries [QUEUE_DEPTH];
    int                       shadow_count = 0;

    int error_count = 0;
    int gap_left = 0;
    int stall_cycles = 0;

    min_priority_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_command),
        .i_value        (i_value),
        .busy           (busy),
        .o_done         (o_done),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one command to the shadow queue and return the outcome it gives
    function automatic t_queue_outcome step_shadow_queue(input logic [CMD_W-1:0] cmd,
                                                         input logic signed [DATA_W-1:0] val);
        t_queue_outcome res;
        int             best;
        int             i;
        res.removed_value = '0;
        res.status        = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                end
            end
            CMD_REMOVE: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // lowest index wins on ties
                    best = 0;
                    for (i = 1; i < shadow_count; i++) begin
                        if (shadow_entries[i] < shadow_entries[best]) best = i;
                    end
                    res.removed_value = shadow_entries[best];
                    for (i = best; i + 1 < shadow_count; i++) begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_count--;
                end
            end
            CMD_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        res.is_empty = (shadow_count == 0);
        res.is_full  = (shadow_count >= QUEUE_DEPTH);
        return res;
    endfunction

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val);
        t_queue_cmd item;
        item.command = cmd;
        item.value   = val;
        cmd_q.push_back(item);
    endtask

    // insert values: extremes, a narrow band for ties, or anything
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7fff_ffff;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    3: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            1, 2, 3: v = $signed($urandom_range(0, 16)) - 32'sd8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // driver: hold each command until it transfers, with random gaps between
    always @(posedge i_clk) begin
        t_queue_cmd item;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                outcome_q.push_back(step_shadow_queue(i_command, i_value));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 15);
                    start    <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    item = cmd_q.pop_front();
                    start     <= 1'b1;
                    i_command <= item.command;
                    i_value   <= item.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result against the oldest expected outcome
    always @(posedge i_clk) begin
        t_queue_outcome want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result with nothing expected: removed_value %0d status %0d",
                         $time, o_removed_value, o_status);
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                if (o_removed_value !== want.removed_value) begin
                    $display("%0t: removed_value expected %0d got %0d",
                             $time, want.removed_value, o_removed_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                    error_count++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0b got %0b",
                             $time, want.is_empty, o_is_empty);
                    error_count++;
                end
                if (o_is_full !== want.is_full) begin
                    $display("%0t: is_full expected %0b got %0b",
                             $time, want.is_full, o_is_full);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int mood;
        int ins_pct;
        int roll;

        // empty queue corners
        add_cmd(CMD_REMOVE, 32'sh1234_5678);
        add_cmd(CMD_CLEAR, -32'sd1);
        add_cmd(CMD_NOP, 32'sh7fff_ffff);
        // fill to depth with extremes and ties
        add_cmd(CMD_INSERT, 32'sh7fff_ffff);
        add_cmd(CMD_INSERT, 32'sh8000_0000);
        add_cmd(CMD_INSERT, 32'sd0);
        add_cmd(CMD_INSERT, -32'sd1);
        add_cmd(CMD_INSERT, 32'sd5);
        add_cmd(CMD_INSERT, 32'sd5);
        add_cmd(CMD_INSERT, -32'sd1);
        add_cmd(CMD_INSERT, 32'sh8000_0000);
        // insert dropped when full, no-op while full
        add_cmd(CMD_INSERT, 32'sd42);
        add_cmd(CMD_NOP, 32'sd0);
        // removes through the tied minimums
        add_cmd(CMD_REMOVE, 32'sd0);
        add_cmd(CMD_REMOVE, 32'sd0);
        add_cmd(CMD_REMOVE, -32'sd1);
        add_cmd(CMD_REMOVE, 32'sd0);
        // clear with entries, then remove on the cleared queue
        add_cmd(CMD_CLEAR, 32'sd0);
        add_cmd(CMD_REMOVE, 32'sd0);
        add_cmd(CMD_INSERT, 32'sh5555_aaaa);
        add_cmd(CMD_REMOVE, 32'sh0);

        // random traffic, biased toward filling, draining or balance in turns
        mood = 2;
        while (cmd_q.size() < ITEM_TARGET) begin
            if (cmd_q.size() % 32 == 0) mood = $urandom_range(0, 2);
            ins_pct = (mood == 0) ? 75 : (mood == 1) ? 25 : 50;
            roll    = $urandom_range(0, 99);
            if (roll < ins_pct) add_cmd(CMD_INSERT, pick_value());
            else if (roll < ins_pct + 3) add_cmd(CMD_CLEAR, $urandom);
            else if (roll < ins_pct + 6) add_cmd(CMD_NOP, $urandom);
            else add_cmd(CMD_REMOVE, $urandom);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every command to transfer and every result to arrive
        while (cmd_q.size() > 0 || start || outcome_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mpq_pkg.sv
hdl/mpq_store.sv
hdl/min_priority_queue_unit.sv
hdl/mpq_checker.sv
verif/min_priority_queue_unit_tb.sv
